// ----- sv/bbf_pkg.sv -----
// Shared types, constants and helpers for the box blur filter.
package bbf_pkg;

  localparam int CFG_W      = 11;  // widest configuration register
  localparam int CFG_IDX_W  = 2;
  localparam int RAD_REG_W  = 3;
  localparam int PIX_W      = 24;
  // command fields sized for the largest supported geometry
  localparam int CMD_AW     = 17;
  localparam int CMD_WW     = 13;
  localparam int CMD_RW     = 4;
  localparam int CMD_CW     = 5;
  localparam int AREA_W     = 10;
  localparam int SUM_W      = 18;
  localparam int STEP_W     = 3;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_RADIUS       = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_last;
  } out_t;

  // one classified item, front to back
  typedef struct packed {
    logic              store;
    logic [PIX_W-1:0]  pix;
    logic [CMD_AW-1:0] wr_addr;
    logic              emit;
    logic [CMD_AW-1:0] rd_addr;
    logic [CMD_CW-1:0] rows;
    logic [CMD_CW-1:0] cols;
    logic [CMD_WW-1:0] width;
    logic [CMD_RW-1:0] radius;
    logic              last;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_TAIL,
    B_DIV,
    B_OUT
  } back_state_t;

  // one restoring division step: subtract the shifted divisor when it fits
  function automatic logic [SUM_W:0] div_step(input logic [SUM_W-1:0] rem,
                                               input logic [SUM_W-1:0] trial);
    logic [SUM_W:0] res;
    begin
      if (rem >= trial) begin
        res = {1'b1, rem - trial};
      end else begin
        res = {1'b0, rem};
      end
      return res;
    end
  endfunction

endpackage

// ----- sv/box_blur_filter_unit.sv -----
// Box blur filter top level: front end, command queue and back end.
// Each item with a result scans a window of rows*cols pixels from the store, then divides the sums;
// rows and cols are the clipped window size (at most 2r+1 each).
// The single read port of the pixel store scans the window one pixel a cycle, and the back
// end takes a new item only once the last result has been taken; items without a result
// pass straight through the back end. The four-entry queue absorbs bursts at the input.
// Reset clears counters, control and registers (1024, 1024, 1); the store is not cleared.
module box_blur_filter_unit
  import bbf_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int QW    = $clog2(MAX_WIDTH * MAX_HEIGHT + (MAX_RADIUS + 1) * MAX_WIDTH + 1);
  localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH + MAX_RADIUS + 1;
  localparam int AW    = $clog2(DEPTH);

  logic push, pop, full, empty;
  cmd_t push_cmd, pop_cmd;

  assign in_ready = !full;

  bbf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS),
    .WW        (WW),
    .HW        (HW),
    .RW        (RW),
    .QW        (QW),
    .AW        (AW),
    .DEPTH     (DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .acc      (in_valid && in_ready),
    .push     (push),
    .cmd      (push_cmd)
  );

  bbf_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_cmd),
    .pop      (pop),
    .pop_data (pop_cmd),
    .full     (full),
    .empty    (empty)
  );

  bbf_back #(
    .AW   (AW),
    .DEPTH(DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .cmd      (pop_cmd),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ----- sv/bbf_front.sv -----
// Front end: configuration registers, frame counters and item classification.
module bbf_front
  import bbf_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 7,
  parameter int WW         = 11,
  parameter int HW         = 11,
  parameter int RW         = 3,
  parameter int QW         = 21,
  parameter int AW         = 14,
  parameter int DEPTH      = 15368
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  in_t                  in_data,
  input  logic                 acc,
  output logic                 push,
  output cmd_t                 cmd
);

  localparam int XW = ((WW > RW) ? WW : RW) + 1;
  localparam int YW = ((HW > RW) ? HW : RW) + 1;
  localparam int TW = WW + HW;

  logic [CFG_W-1:0]     width_reg, height_reg;
  logic [RAD_REG_W-1:0] radius_reg;
  logic [QW-1:0]        q;
  logic [WW-1:0]        ox;
  logic [HW-1:0]        oy;
  logic [AW-1:0]        pa, wa;

  logic [WW-1:0] w_e;
  logic [HW-1:0] h_e;
  logic [RW-1:0] r_e;
  logic [TW-1:0] total;
  logic [QW-1:0] lag;
  logic          drop, store, emit, last;
  logic [XW-1:0] xs, xr, xw, x0, x1;
  logic [YW-1:0] ys, yr, yh, y0, y1;
  logic [AW-1:0] off, rd;

  always_comb begin
    if (width_reg == '0) w_e = WW'(1);
    else if (32'(width_reg) > MAX_WIDTH) w_e = WW'(MAX_WIDTH);
    else w_e = WW'(width_reg);
    if (height_reg == '0) h_e = HW'(1);
    else if (32'(height_reg) > MAX_HEIGHT) h_e = HW'(MAX_HEIGHT);
    else h_e = HW'(height_reg);
    if (radius_reg == '0) r_e = RW'(1);
    else if (32'(radius_reg) > MAX_RADIUS) r_e = RW'(MAX_RADIUS);
    else r_e = RW'(radius_reg);
  end

  assign total = TW'(w_e) * TW'(h_e);
  assign lag   = QW'(r_e) * QW'(w_e) + QW'(r_e);
  assign drop  = in_data.mode && (q == '0);
  assign store = q < QW'(total);
  assign emit  = q >= lag;
  assign last  = emit && (ox == w_e - WW'(1)) && (oy == h_e - HW'(1));

  // window bounds clipped to the frame
  always_comb begin
    xs = XW'(ox);
    xr = XW'(r_e);
    xw = XW'(w_e);
    ys = YW'(oy);
    yr = YW'(r_e);
    yh = YW'(h_e);
    x0 = (xs >= xr) ? xs - xr : '0;
    x1 = (xs + xr < xw) ? xs + xr : xw - XW'(1);
    y0 = (ys >= yr) ? ys - yr : '0;
    y1 = (ys + yr < yh) ? ys + yr : yh - YW'(1);
  end

  assign off = AW'(ys - y0) * AW'(w_e) + AW'(xs - x0);
  assign rd  = (pa >= off) ? pa - off : pa - off + AW'(DEPTH);

  assign push = acc && !drop;

  always_comb begin
    cmd.store   = store;
    cmd.pix     = in_data.mode ? '0 : {in_data.red_in, in_data.green_in, in_data.blue_in};
    cmd.wr_addr = CMD_AW'(wa);
    cmd.emit    = emit;
    cmd.rd_addr = CMD_AW'(rd);
    cmd.rows    = CMD_CW'(y1 - y0 + YW'(1));
    cmd.cols    = CMD_CW'(x1 - x0 + XW'(1));
    cmd.width   = CMD_WW'(w_e);
    cmd.radius  = CMD_RW'(r_e);
    cmd.last    = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= CFG_W'(1024);
      height_reg <= CFG_W'(1024);
      radius_reg <= RAD_REG_W'(1);
      q  <= '0;
      ox <= '0;
      oy <= '0;
      pa <= '0;
      wa <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
        CFG_FRAME_HEIGHT: height_reg <= cfg_data;
        CFG_RADIUS:       radius_reg <= cfg_data[RAD_REG_W-1:0];
        default: ;
      endcase
      if (cfg_idx_t'(cfg_index) != CFG_UNUSED) begin
        q  <= '0;
        ox <= '0;
        oy <= '0;
        pa <= '0;
        wa <= '0;
      end
    end else if (push) begin
      if (last) begin
        q  <= '0;
        ox <= '0;
        oy <= '0;
        pa <= '0;
        wa <= '0;
      end else begin
        q  <= q + QW'(1);
        wa <= (wa == AW'(DEPTH - 1)) ? '0 : wa + AW'(1);
        if (emit) begin
          pa <= (pa == AW'(DEPTH - 1)) ? '0 : pa + AW'(1);
          if (ox == w_e - WW'(1)) begin
            ox <= '0;
            oy <= oy + HW'(1);
          end else begin
            ox <= ox + WW'(1);
          end
        end
      end
    end
  end

endmodule

// ----- sv/bbf_fifo.sv -----
// Short command queue between front and back.
module bbf_fifo
  import bbf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic full,
  output logic empty
);

  localparam int QD = 4;
  localparam int PW = $clog2(QD);

  cmd_t          entries [QD];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   count;

  assign full     = count == (PW+1)'(QD);
  assign empty    = count == '0;
  assign pop_data = entries[rp];

  always_ff @(posedge clk) begin
    if (push) entries[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + PW'(1);
      if (pop) rp <= rp + PW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + (PW+1)'(1))
    else $error("queue count wrong");
`endif

endmodule

// ----- sv/bbf_back.sv -----
// Back end: pixel store, serial window scan and per-channel division.
module bbf_back
  import bbf_pkg::*;
#(
  parameter int AW    = 14,
  parameter int DEPTH = 15368
) (
  input  logic clk,
  input  logic rst,
  input  logic empty,
  input  cmd_t cmd,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  back_state_t state, state_next;

  logic [PIX_W-1:0]  mem [DEPTH];
  logic [PIX_W-1:0]  rd_q;
  logic              rd_pend;
  logic [AW-1:0]     row_addr, addr;
  logic [CMD_CW-1:0] row_cnt, col_cnt, rows, cols;
  logic [CMD_WW-1:0] width;
  logic              last;
  logic [AREA_W-1:0] area;
  logic [SUM_W-1:0]  sr, sg, sb;
  logic [7:0]        qr, qg, qb;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  trial;
  logic [SUM_W:0]    dr, dg, db;
  logic [AW:0]       inc_sum, row_sum;
  logic [AW-1:0]     inc_addr, row_next;
  logic [AREA_W-1:0] side;
  logic              scan_end_col, scan_end_row;

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  assign scan_end_col = col_cnt == cols - CMD_CW'(1);
  assign scan_end_row = row_cnt == rows - CMD_CW'(1);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      B_IDLE: begin
        pop = !empty;
        if (!empty && cmd.emit) state_next = B_SCAN;
      end
      B_SCAN: if (scan_end_col && scan_end_row) state_next = B_TAIL;
      B_TAIL: state_next = B_DIV;
      B_DIV:  if (step == '0) state_next = B_OUT;
      B_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // address steps wrap around the circular store
  assign inc_sum  = (AW+1)'(addr) + (AW+1)'(1);
  assign inc_addr = (inc_sum >= (AW+1)'(DEPTH)) ? AW'(inc_sum - (AW+1)'(DEPTH))
                                                 : AW'(inc_sum);
  assign row_sum  = (AW+1)'(row_addr) + (AW+1)'(width);
  assign row_next = (row_sum >= (AW+1)'(DEPTH)) ? AW'(row_sum - (AW+1)'(DEPTH))
                                                 : AW'(row_sum);

  assign side  = AREA_W'({cmd.radius, 1'b1});
  assign trial = SUM_W'(area) << step;
  assign dr    = div_step(sr, trial);
  assign dg    = div_step(sg, trial);
  assign db    = div_step(sb, trial);

  always_ff @(posedge clk) begin
    if (pop && cmd.store) mem[AW'(cmd.wr_addr)] <= cmd.pix;
    rd_q <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= state == B_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        row_addr <= AW'(cmd.rd_addr);
        addr     <= AW'(cmd.rd_addr);
        row_cnt  <= '0;
        col_cnt  <= '0;
        rows     <= cmd.rows;
        cols     <= cmd.cols;
        width    <= cmd.width;
        last     <= cmd.last;
        area     <= AREA_W'(side * side);
        sr       <= '0;
        sg       <= '0;
        sb       <= '0;
        qr       <= '0;
        qg       <= '0;
        qb       <= '0;
        step     <= STEP_W'(7);
      end
      B_SCAN, B_TAIL: begin
        if (state == B_SCAN) begin
          if (scan_end_col) begin
            col_cnt  <= '0;
            row_cnt  <= row_cnt + CMD_CW'(1);
            row_addr <= row_next;
            addr     <= row_next;
          end else begin
            col_cnt <= col_cnt + CMD_CW'(1);
            addr    <= inc_addr;
          end
        end
        if (rd_pend) begin
          sr <= sr + SUM_W'(rd_q[23:16]);
          sg <= sg + SUM_W'(rd_q[15:8]);
          sb <= sb + SUM_W'(rd_q[7:0]);
        end
      end
      B_DIV: begin
        sr       <= dr[SUM_W-1:0];
        sg       <= dg[SUM_W-1:0];
        sb       <= db[SUM_W-1:0];
        qr[step] <= dr[SUM_W];
        qg[step] <= dg[SUM_W];
        qb[step] <= db[SUM_W];
        step     <= step - STEP_W'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data.red_out    = qr;
    out_data.green_out  = qg;
    out_data.blue_out   = qb;
    out_data.alpha_out  = ALPHA_OPAQUE;
    out_data.frame_last = last;
  end

`ifndef SYNTH
  a_scan_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCAN) |-> (row_cnt < rows && col_cnt < cols))
    else $error("window scan out of range");
  a_addr_in_store: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCAN) |-> (32'(addr) < DEPTH))
    else $error("store address out of range");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(qr) && $stable(qg) && $stable(qb)))
    else $error("result changed while waiting");
`endif

endmodule

// ----- sim/box_blur_filter_unit_tb.sv -----
// Self-checking testbench for the streaming box blur filter unit.
`timescale 1ns / 100ps

module box_blur_filter_unit_tb;
  import bbf_pkg::*;

  localparam int LIM_W = 1024;
  localparam int LIM_H = 1024;
  localparam int LIM_R = 7;
  localparam int IMG_DEPTH = (2 * LIM_R + 1) * LIM_W + LIM_R + 1;
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;
  localparam int SETTLE_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  box_blur_filter_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // mirror of the block's registers and frame state
  logic [10:0] frame_w_reg = 11'd1024;
  logic [10:0] frame_h_reg = 11'd1024;
  logic [2:0] radius_reg = 3'd1;
  logic [23:0] frame_pixels [IMG_DEPTH];
  int unsigned frame_pos = 0;

  in_t pixel_queue [$];
  out_t blur_results [$];
  int errors = 0;
  int items_queued = 0;
  int quiet_cycles = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic blur_step(input in_t it);
    int unsigned w, h, r, total, lag, q, p, y, x, y0, y1, x0, x1, area;
    int unsigned sr, sg, sb, yy, xx;
    logic [23:0] v;
    out_t e;
    w = clamp_dim(frame_w_reg, LIM_W);
    h = clamp_dim(frame_h_reg, LIM_H);
    r = clamp_dim(radius_reg, LIM_R);
    total = w * h;
    lag = r * w + r;
    q = frame_pos;
    if (it.mode == MODE_DRAIN && q == 0) return;
    if (q < total)
      frame_pixels[q % IMG_DEPTH] = (it.mode == MODE_DRAIN) ? 24'd0 :
                                    {it.red_in, it.green_in, it.blue_in};
    frame_pos = q + 1;
    if (q < lag) return;
    p = q - lag;
    if (p >= total) return;
    y = p / w;
    x = p % w;
    y0 = (y >= r) ? y - r : 0;
    y1 = (y + r < h) ? y + r : h - 1;
    x0 = (x >= r) ? x - r : 0;
    x1 = (x + r < w) ? x + r : w - 1;
    area = (2 * r + 1) * (2 * r + 1);
    sr = 0; sg = 0; sb = 0;
    for (yy = y0; yy <= y1; yy++) begin
      for (xx = x0; xx <= x1; xx++) begin
        v = frame_pixels[(yy * w + xx) % IMG_DEPTH];
        sr += v[23:16];
        sg += v[15:8];
        sb += v[7:0];
      end
    end
    e.red_out = 8'(sr / area);
    e.green_out = 8'(sg / area);
    e.blue_out = 8'(sb / area);
    e.alpha_out = ALPHA_OPAQUE;
    e.frame_last = (p == total - 1);
    if (p == total - 1) frame_pos = 0;
    blur_results.push_back(e);
  endtask

  // driver: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) blur_step(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pixel_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall style redrawn at random among always ready, random and periodic
  int rx_cycle = 0;
  int rx_style = 0;
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_style = $urandom_range(0, 2);
    case (rx_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= (rx_cycle % 16 >= 7);
    endcase
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    out_t e;
    if (!rst && out_valid && out_ready) begin
      if (blur_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = blur_results.pop_front();
        check_field("red_out", e.red_out, out_data.red_out);
        check_field("green_out", e.green_out, out_data.green_out);
        check_field("blue_out", e.blue_out, out_data.blue_out);
        check_field("alpha_out", e.alpha_out, out_data.alpha_out);
        check_field("frame_last", e.frame_last, out_data.frame_last);
      end
    end
  end

  // watchdog on cycles with no item moving on either side and no configuration write
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("box_blur_filter_unit: mismatch");
      $finish;
    end
  end

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_FRAME_WIDTH: begin frame_w_reg = val; frame_pos = 0; end
      CFG_FRAME_HEIGHT: begin frame_h_reg = val; frame_pos = 0; end
      CFG_RADIUS: begin radius_reg = val[2:0]; frame_pos = 0; end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sampled mid-cycle so the driver's updates at the edge have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_queue.size() > 0 || in_valid || blur_results.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_t rand_item(input logic m);
    in_t it;
    it.mode = m;
    it.red_in = rand_chan();
    it.green_in = rand_chan();
    it.blue_in = rand_chan();
    return it;
  endfunction

  // one frame: pixels, then drain items up to the closing result;
  // a little noise: stray drains, black drains mid-frame, pixels in the tail
  task automatic push_frame(input bit noisy);
    int unsigned w, h, r, n;
    w = clamp_dim(frame_w_reg, LIM_W);
    h = clamp_dim(frame_h_reg, LIM_H);
    r = clamp_dim(radius_reg, LIM_R);
    if (noisy && $urandom_range(0, 3) == 0) pixel_queue.push_back(rand_item(MODE_DRAIN));
    for (n = 0; n < w * h; n++)
      pixel_queue.push_back(rand_item((noisy && $urandom_range(0, 19) == 0) ?
                                      MODE_DRAIN : MODE_PIXEL));
    for (n = 0; n < r * w + r; n++)
      pixel_queue.push_back(rand_item((noisy && $urandom_range(0, 4) == 0) ?
                                      MODE_PIXEL : MODE_DRAIN));
    items_queued += w * h + r * w + r;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input logic [CFG_W-1:0] r, input int frames, input bit noisy);
    int f;
    wait_idle();
    cfg_write(CFG_FRAME_WIDTH, w);
    cfg_write(CFG_FRAME_HEIGHT, h);
    cfg_write(CFG_RADIUS, r);
    if ($urandom_range(0, 2) == 0) cfg_write(CFG_UNUSED, CFG_W'($urandom));
    for (f = 0; f < frames; f++) push_frame(noisy);
  endtask

  initial begin
    in_t it;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: stray drain with no frame, extreme colours, radius zero clamps
    wait_idle();
    cfg_write(CFG_FRAME_WIDTH, 11'd3);
    cfg_write(CFG_FRAME_HEIGHT, 11'd3);
    cfg_write(CFG_RADIUS, 11'd0);
    cfg_write(CFG_UNUSED, 11'h7FF);
    pixel_queue.push_back(rand_item(MODE_DRAIN));
    for (int i = 0; i < 9; i++) begin
      it.mode = (i == 4) ? MODE_DRAIN : MODE_PIXEL;
      it.red_in = (i % 2) ? 8'd255 : 8'd0;
      it.green_in = 8'd255;
      it.blue_in = (i % 3) ? 8'd0 : 8'd255;
      pixel_queue.push_back(it);
    end
    it = rand_item(MODE_PIXEL);
    pixel_queue.push_back(it);
    for (int i = 0; i < 3; i++) pixel_queue.push_back(rand_item(MODE_DRAIN));
    items_queued += 14;
    run_phase(11'd0, 11'd1, 11'd7, 2, 1'b0);        // width zero, single pixel
    run_phase(11'd1, 11'd1, 11'd7, 1, 1'b1);

    // tallest column, cut short by the next configuration write
    wait_idle();
    cfg_write(CFG_FRAME_WIDTH, 11'd1);
    cfg_write(CFG_FRAME_HEIGHT, 11'd2047);
    cfg_write(CFG_RADIUS, 11'd2);
    for (int i = 0; i < 60; i++) pixel_queue.push_back(rand_item(MODE_PIXEL));
    items_queued += 60;

    run_phase(11'd16, 11'd0, 11'd7, 1, 1'b1);

    while (items_queued < 560) begin
      run_phase(($urandom_range(0, 5) == 0) ? 11'($urandom_range(14, 20)) :
                11'($urandom_range(1, 10)),
                11'($urandom_range(1, 8)), 11'($urandom_range(0, 7)),
                $urandom_range(1, 2), 1'b1);
    end

    wait_idle();
    if (errors == 0) $display("box_blur_filter_unit: match");
    else $display("box_blur_filter_unit: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
sv/bbf_pkg.sv
sv/bbf_front.sv
sv/bbf_fifo.sv
sv/bbf_back.sv
sv/box_blur_filter_unit.sv
sim/box_blur_filter_unit_tb.sv
